// ===== design/hpc_pkg.sv =====
// Shared types, register codes and arithmetic helpers of the hodgepodge cell update unit.
package hpc_pkg;

  localparam int unsigned CellW   = 8;
  localparam int unsigned CntW    = 4;
  localparam int unsigned RecipW  = 17;
  localparam int unsigned RecipSh = 16;
  localparam int unsigned ProdW   = CellW + RecipW;
  localparam int unsigned QSumW   = CntW + 1;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [CellW-1:0] cell_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STATE_COUNT      = 3'd0,
    CFG_INFECTED_DIVISOR = 3'd1,
    CFG_ILL_DIVISOR      = 3'd2,
    CFG_INFECTION_RATE   = 3'd3,
    CFG_VARIANT          = 3'd4
  } cfg_idx_e;

  // Window census: counts, wrapping sum and the class of the centre cell.
  typedef struct packed {
    logic [CntW-1:0] ill_cnt;
    logic [CntW-1:0] inf_cnt;
    cell_t           total;
    logic            centre_zero;
    logic            centre_below;
  } census_t;

  // Reciprocal ceil(2^16 / (n + 1)) for n = 0..9. With a sum below 256 the
  // truncated product is the exact quotient, so no correction step is needed.
  function automatic logic [RecipW-1:0] recip_of(input logic [CntW-1:0] n);
    logic [RecipW-1:0] r;
    unique case (n)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd32768;
      4'd2:    r = 17'd21846;
      4'd3:    r = 17'd16384;
      4'd4:    r = 17'd13108;
      4'd5:    r = 17'd10923;
      4'd6:    r = 17'd9363;
      4'd7:    r = 17'd8192;
      4'd8:    r = 17'd7282;
      4'd9:    r = 17'd6554;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Restoring division of a count (at most nine) by a divisor of at least one.
  function automatic logic [CntW-1:0] div_count(input logic [CntW-1:0] n,
                                                input cell_t           d);
    logic [CntW-1:0] q;
    cell_t           rem;
    q   = '0;
    rem = '0;
    for (int i = CntW - 1; i >= 0; i--) begin
      rem = {rem[CellW-2:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// ===== design/hodgepodge_cell_update_unit.sv =====
// Top level of the hodgepodge cell update unit: configuration registers and three-stage pipeline.
//
// The unit takes one 3x3 window of 8-bit cells per item and returns the
// centre's next hodgepodge state as exactly one result item. It is a
// three-stage pipeline that accepts a new window every cycle while in_stall_o
// is low: the first stage counts ill and infected cells and forms the
// wrapping sum, the second divides the counts by k1 and k2 and multiplies
// the sum by a reciprocal of (infected + 1), and the third adds g, selects
// by the centre's class and caps at the ill level. The result passes the
// stage 1, 2 and 3 registers in turn after its window is accepted and then
// stays on the output until taken. When the output is stalled, the stages
// fill one by one and in_stall_o rises only once all three hold an item.
// Configuration writes take effect at once and must be made while no item is in flight.
module hodgepodge_cell_update_unit import hpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CellW-1:0]   cfg_wdata_i,
  // Input item channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CellW-1:0]   up_left_i,
  input  logic [CellW-1:0]   up_mid_i,
  input  logic [CellW-1:0]   up_right_i,
  input  logic [CellW-1:0]   mid_left_i,
  input  logic [CellW-1:0]   centre_i,
  input  logic [CellW-1:0]   mid_right_i,
  input  logic [CellW-1:0]   down_left_i,
  input  logic [CellW-1:0]   down_mid_i,
  input  logic [CellW-1:0]   down_right_i,
  // Result item channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CellW-1:0]   next_state_o
);

  // Configuration registers, reset to the documented defaults.
  cell_t state_count_q;
  cell_t infected_divisor_q;
  cell_t ill_divisor_q;
  cell_t infection_rate_q;
  logic  variant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q      <= 8'd255;
      infected_divisor_q <= 8'd1;
      ill_divisor_q      <= 8'd1;
      infection_rate_q   <= 8'd0;
      variant_q          <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STATE_COUNT:      state_count_q      <= cfg_wdata_i;
        CFG_INFECTED_DIVISOR: infected_divisor_q <= cfg_wdata_i;
        CFG_ILL_DIVISOR:      ill_divisor_q      <= cfg_wdata_i;
        CFG_INFECTION_RATE:   infection_rate_q   <= cfg_wdata_i;
        CFG_VARIANT:          variant_q          <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // The ill level is q in the net rule and q-1 (wrapping) in the classic rule.
  cell_t level;
  cell_t div1;
  cell_t div2;
  assign level = variant_q ? state_count_q : state_count_q - 8'd1;
  // A divisor of zero behaves as one.
  assign div1  = (infected_divisor_q == '0) ? 8'd1 : infected_divisor_q;
  assign div2  = (ill_divisor_q == '0) ? 8'd1 : ill_divisor_q;

  // Stage enables: a stage moves when it is empty or the next one moves.
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  // Stage 1: window census.
  cell_t   cells [9];
  census_t census;
  census_t cen1_q;

  assign cells[0] = up_left_i;
  assign cells[1] = up_mid_i;
  assign cells[2] = up_right_i;
  assign cells[3] = mid_left_i;
  assign cells[4] = centre_i;
  assign cells[5] = mid_right_i;
  assign cells[6] = down_left_i;
  assign cells[7] = down_mid_i;
  assign cells[8] = down_right_i;

  hpc_census u_census (
    .cells_i   (cells),
    .level_i   (level),
    .variant_i (variant_q),
    .census_o  (census)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      cen1_q <= census;
    end
  end

  // Stage 2: count quotients for a zero centre, reciprocal product for the average.
  logic [QSumW-1:0] qsum_d, qsum2_q;
  logic [ProdW-1:0] prod_d, prod2_q;
  logic             zero2_q, below2_q;

  assign qsum_d = QSumW'(div_count(cen1_q.inf_cnt, div1))
                + QSumW'(div_count(cen1_q.ill_cnt, div2));
  assign prod_d = ProdW'(cen1_q.total) * ProdW'(recip_of(cen1_q.inf_cnt));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      qsum2_q  <= qsum_d;
      prod2_q  <= prod_d;
      zero2_q  <= cen1_q.centre_zero;
      below2_q <= cen1_q.centre_below;
    end
  end

  // Stage 3: select by centre class, add g, cap at the ill level.
  cell_t avg;
  cell_t raw;
  cell_t next_d, next_q;

  assign avg = prod2_q[RecipSh +: CellW];

  always_comb begin
    priority if (zero2_q) begin
      raw = CellW'(qsum2_q);
    end else if (below2_q) begin
      raw = avg + infection_rate_q;
    end else begin
      raw = '0;
    end
    next_d = (raw > level) ? level : raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      next_q <= next_d;
    end
  end

  assign out_valid_o  = v3_q;
  assign next_state_o = next_q;

  // A delivered state never exceeds the ill level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (next_state_o <= level))
    else $error("result above ill level");

  // Input backpressure only arises with all three stages occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with a free stage");

  // An item in stage 1 that may advance reaches stage 2.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> v2_q)
    else $error("item lost between stage 1 and stage 2");

  // A held result, with an item behind it in stage 2, is not dropped while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && out_stall_i && v2_q) |=> (v3_q && v2_q))
    else $error("pipeline dropped an item under stall");

endmodule

// ===== design/hpc_census.sv =====
// Classifies the nine window cells and forms the ill count, infected count and wrapping sum.
module hpc_census import hpc_pkg::*; (
  input  cell_t               cells_i [9],
  input  cell_t               level_i,
  input  logic                variant_i,
  output census_t             census_o
);

  logic [8:0] ill_bits;
  logic [8:0] inf_bits;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ill_bits[i] = (cells_i[i] == level_i);
      // The net rule counts every nonzero cell as infected, ill ones too.
      inf_bits[i] = (cells_i[i] != '0) && (variant_i || (cells_i[i] != level_i));
    end
  end

  always_comb begin
    logic [CntW-1:0] ill_sum;
    logic [CntW-1:0] inf_sum;
    cell_t           total;
    ill_sum = '0;
    inf_sum = '0;
    total   = '0;
    for (int i = 0; i < 9; i++) begin
      ill_sum = ill_sum + CntW'(ill_bits[i]);
      inf_sum = inf_sum + CntW'(inf_bits[i]);
      total   = total + cells_i[i];
    end
    census_o.ill_cnt      = ill_sum;
    census_o.inf_cnt      = inf_sum;
    census_o.total        = total;
    census_o.centre_zero  = (cells_i[4] == '0);
    census_o.centre_below = (cells_i[4] != '0) && (cells_i[4] < level_i);
  end

endmodule
